// ===== rtl/bm3_pkg.sv =====
package bm3_pkg;

  // Geometry limits
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned MIN_DIM    = 3;

  // Field widths
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
  localparam int unsigned DIM_W  = 11;
  localparam int unsigned SUM_W  = 12;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] LINE_WIDTH_RST   = 11'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  // Divide by nine: (sum * 7282) >> 16 is exact for sum below 3641
  localparam int unsigned RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;
  localparam logic [SUM_W-1:0] SUM_MAX = 12'd2295;

  // Result buffer
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;

  // Line store entry: row r-2 and row r-1 at one column
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] lower;
  } line_pair_t;

  // Window position tag (top-left corner)
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } tag_t;

  // One finished result
  typedef struct packed {
    logic [PIX_W-1:0] mean;
    tag_t             tag;
  } result_t;

  // Clamp a configured dimension to [MIN_DIM, hi]
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v < DIM_W'(MIN_DIM)) begin
      r = DIM_W'(MIN_DIM);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/box_mean_3x3.sv =====
// 3x3 box mean over an 8-bit gray pixel stream in raster order.
// Pixel channel: pixel_valid_i / pixel_stall_o with pixel_i; a transaction
// completes when valid is high and stall is low. Result channel: out_valid_o
// / out_stall_i with mean_o, out_row_o, out_col_o (window's top-left corner).
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i (0 line_width,
// 1 frame_height) and cfg_data_i; ready is always high. Write only while idle.
// Values outside [3, 1024] act as the nearest limit.
// Throughput: one pixel per cycle while pixel_stall_o is low. A result passes the
// line store read, the window sum register and the divide into the result buffer.
// Rows 0-1 and columns 0-1 of each row produce no result.
// Both line stores share one 1024 x 16 RAM with one read and one write port;
// each column is read on accept and written back the cycle after.
// A four-entry result buffer decouples the sides: pixel_stall_o rises when the
// buffer plus in-flight results could reach its depth, so a stalled receiver
// backs up the pixel stream after a few transactions and nothing is dropped.
// Reset clears counters, window registers and the buffer; line store
// contents are undefined until written by the first rows of a frame.
module box_mean_3x3 (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 pixel_valid_i,
  output logic                                 pixel_stall_o,
  input  logic [bm3_pkg::PIX_W-1:0]            pixel_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [bm3_pkg::PIX_W-1:0]            mean_o,
  output logic [bm3_pkg::ROW_W-1:0]            out_row_o,
  output logic [bm3_pkg::COL_W-1:0]            out_col_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bm3_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [bm3_pkg::DIM_W-1:0]            cfg_data_i
);

  logic [bm3_pkg::DIM_W-1:0]  line_width_q;
  logic [bm3_pkg::DIM_W-1:0]  frame_height_q;
  logic [bm3_pkg::DIM_W-1:0]  width_eff;
  logic [bm3_pkg::DIM_W-1:0]  height_eff;
  logic [bm3_pkg::COL_W-1:0]  col_q, col_d;
  logic [bm3_pkg::ROW_W-1:0]  row_q, row_d;
  logic [bm3_pkg::DIM_W-1:0]  col_inc;
  logic [bm3_pkg::DIM_W-1:0]  row_inc;
  logic                       in_fire;
  logic                       cfg_fire;

  // Stage 1: line store data arrives
  logic                       s1_valid_q;
  logic                       s1_emit_q;
  logic [bm3_pkg::PIX_W-1:0]  s1_px_q;
  logic [bm3_pkg::COL_W-1:0]  s1_col_q;
  bm3_pkg::tag_t              s1_tag_q;
  bm3_pkg::line_pair_t        rd_pair;
  bm3_pkg::line_pair_t        wr_pair;

  logic                       sum_valid;
  logic [bm3_pkg::SUM_W-1:0]  sum;
  bm3_pkg::tag_t              sum_tag;
  logic [bm3_pkg::FIFO_CNT_W-1:0] buf_count;
  logic [bm3_pkg::FIFO_CNT_W-1:0] pending;
  bm3_pkg::result_t           result;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= bm3_pkg::LINE_WIDTH_RST;
      frame_height_q <= bm3_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        bm3_pkg::REG_LINE_WIDTH:   line_width_q   <= cfg_data_i;
        bm3_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign width_eff  = bm3_pkg::clamp_dim(line_width_q,
                                         bm3_pkg::DIM_W'(bm3_pkg::MAX_WIDTH));
  assign height_eff = bm3_pkg::clamp_dim(frame_height_q,
                                         bm3_pkg::DIM_W'(bm3_pkg::MAX_HEIGHT));

  // Credit check: buffered plus in-flight results
  assign pending = buf_count + bm3_pkg::FIFO_CNT_W'(s1_valid_q)
                 + bm3_pkg::FIFO_CNT_W'(sum_valid);
  assign pixel_stall_o = (pending >= bm3_pkg::FIFO_CNT_W'(bm3_pkg::FIFO_DEPTH));
  assign in_fire = pixel_valid_i & ~pixel_stall_o;

  // Raster position counters
  always_comb begin
    col_inc = bm3_pkg::DIM_W'(col_q) + 1'b1;
    row_inc = bm3_pkg::DIM_W'(row_q) + 1'b1;
    col_d   = col_inc[bm3_pkg::COL_W-1:0];
    row_d   = row_q;
    if (col_inc >= width_eff) begin
      col_d = '0;
      row_d = (row_inc >= height_eff) ? '0 : row_inc[bm3_pkg::ROW_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_emit_q    <= (row_q >= bm3_pkg::ROW_W'(2)) && (col_q >= bm3_pkg::COL_W'(2));
      s1_px_q      <= pixel_i;
      s1_col_q     <= col_q;
      s1_tag_q.row <= row_q - bm3_pkg::ROW_W'(2);
      s1_tag_q.col <= col_q - bm3_pkg::COL_W'(2);
    end
  end

  // Line store write-back: lower row moves up, new pixel becomes lower row
  assign wr_pair.upper = rd_pair.lower;
  assign wr_pair.lower = s1_px_q;

  bm3_line_ram u_line_ram (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (col_q),
    .rd_data_o (rd_pair),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_pair)
  );

  bm3_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_i     (s1_valid_q),
    .emit_i      (s1_emit_q),
    .tag_i       (s1_tag_q),
    .up_i        (rd_pair.upper),
    .lo_i        (rd_pair.lower),
    .px_i        (s1_px_q),
    .sum_valid_o (sum_valid),
    .sum_o       (sum),
    .tag_o       (sum_tag)
  );

  bm3_out_buf u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (sum_valid),
    .sum_i    (sum),
    .tag_i    (sum_tag),
    .count_o  (buf_count),
    .valid_o  (out_valid_o),
    .stall_i  (out_stall_i),
    .result_o (result)
  );

  assign mean_o    = result.mean;
  assign out_row_o = result.tag.row;
  assign out_col_o = result.tag.col;

`ifndef SYNTHESIS
  // A column is never read while its write-back is still pending
  a_no_raw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && in_fire) |-> (s1_col_q != col_q))
    else $error("line store read overlaps pending write-back");

  // Back-pressure only when results are buffered or in flight
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_stall_o |-> (buf_count != '0))
    else $error("pixel stall without buffered results");

  // A result enters the divide stage in the cycle after a qualifying stage-1 item
  a_sum_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_valid |-> $past(s1_valid_q && s1_emit_q))
    else $error("window sum without source pixel");
`endif

endmodule

// ===== rtl/bm3_line_ram.sv =====
module bm3_line_ram (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [bm3_pkg::COL_W-1:0] rd_addr_i,
  output bm3_pkg::line_pair_t  rd_data_o,
  input  logic                 wr_en_i,
  input  logic [bm3_pkg::COL_W-1:0] wr_addr_i,
  input  bm3_pkg::line_pair_t  wr_data_i
);

  bm3_pkg::line_pair_t mem_q [bm3_pkg::MAX_WIDTH];
  bm3_pkg::line_pair_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/bm3_window.sv =====
module bm3_window (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       shift_i,
  input  logic                       emit_i,
  input  bm3_pkg::tag_t              tag_i,
  input  logic [bm3_pkg::PIX_W-1:0]  up_i,
  input  logic [bm3_pkg::PIX_W-1:0]  lo_i,
  input  logic [bm3_pkg::PIX_W-1:0]  px_i,
  output logic                       sum_valid_o,
  output logic [bm3_pkg::SUM_W-1:0]  sum_o,
  output bm3_pkg::tag_t              tag_o
);

  // win[3*r + c]: r = 0 top row, c = 0 leftmost column
  logic [bm3_pkg::PIX_W-1:0] win_q [9];
  logic [bm3_pkg::PIX_W-1:0] win_d [9];
  logic [bm3_pkg::SUM_W-1:0] row_sum [3];
  logic [bm3_pkg::SUM_W-1:0] sum_d;
  logic [bm3_pkg::SUM_W-1:0] sum_q;
  bm3_pkg::tag_t             tag_q;
  logic                      sum_valid_q;

  // Shift left by one column, new column enters on the right
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[3*r]   = win_q[3*r+1];
      win_d[3*r+1] = win_q[3*r+2];
    end
    win_d[2] = up_i;
    win_d[5] = lo_i;
    win_d[8] = px_i;
  end

  // Row sums, then total
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = bm3_pkg::SUM_W'(win_d[3*r]) + bm3_pkg::SUM_W'(win_d[3*r+1])
                 + bm3_pkg::SUM_W'(win_d[3*r+2]);
    end
    sum_d = row_sum[0] + row_sum[1] + row_sum[2];
  end

  // Window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (shift_i) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= win_d[k];
      end
    end
  end

  // Sum stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else begin
      sum_valid_q <= shift_i & emit_i;
    end
  end

  // Sum stage payload
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sum_q <= sum_d;
      tag_q <= tag_i;
    end
  end

  assign sum_valid_o = sum_valid_q;
  assign sum_o       = sum_q;
  assign tag_o       = tag_q;

`ifndef SYNTHESIS
  // Nine 8-bit pixels never exceed the divider's exact range
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_valid_q |-> (sum_q <= bm3_pkg::SUM_MAX))
    else $error("window sum out of range");
`endif

endmodule

// ===== rtl/bm3_out_buf.sv =====
module bm3_out_buf (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic [bm3_pkg::SUM_W-1:0]       sum_i,
  input  bm3_pkg::tag_t                   tag_i,
  output logic [bm3_pkg::FIFO_CNT_W-1:0]  count_o,
  output logic                            valid_o,
  input  logic                            stall_i,
  output bm3_pkg::result_t                result_o
);

  bm3_pkg::result_t                 buf_q [bm3_pkg::FIFO_DEPTH];
  logic [bm3_pkg::FIFO_PTR_W-1:0]   wr_ptr_q;
  logic [bm3_pkg::FIFO_PTR_W-1:0]   rd_ptr_q;
  logic [bm3_pkg::FIFO_CNT_W-1:0]   count_q;
  logic [bm3_pkg::PROD_W-1:0]       prod;
  bm3_pkg::result_t                 entry;
  logic                             pop;

  // Divide by nine through the reciprocal
  assign prod = bm3_pkg::PROD_W'(sum_i) * bm3_pkg::PROD_W'(bm3_pkg::RECIP_9);
  assign entry.mean = prod[bm3_pkg::RECIP_SHIFT +: bm3_pkg::PIX_W];
  assign entry.tag  = tag_i;

  assign pop = valid_o & ~stall_i;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign valid_o  = (count_q != '0);
  assign result_o = buf_q[rd_ptr_q];
  assign count_o  = count_q;

`ifndef SYNTHESIS
  // Upstream credit check must keep the buffer from overflowing
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < bm3_pkg::FIFO_CNT_W'(bm3_pkg::FIFO_DEPTH)) || pop)
    else $error("result buffer overflow");
`endif

endmodule
